@@ src/wfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfa_pkg
// Shared types, register codes, reset values and the cosine table builder for
// the window function block.
// ----------------------------------------------------------------------------
package wfa_pkg;

  // Fixed sizes of the block
  localparam int MAX_LENGTH      = 4096;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int COS_ADDR_W      = $clog2(COS_TABLE_DEPTH);
  localparam int COS_W           = 17;   // signed Q1.15 with room for +1.0
  localparam int COEF_W          = 18;   // signed window coefficient
  localparam int LEN_W           = 13;
  localparam int PHASE_W         = 25;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 25;

  // Q-format constants
  localparam logic [PHASE_W-1:0] Q24_ONE     = 25'd16777216;
  localparam logic [PHASE_W-1:0] SINE_OFFSET = 25'd12582912;  // three quarter turns
  localparam logic [PHASE_W-1:0] ACC_MAX     = 25'h1FFFFFF;
  localparam logic [63:0]        Q30_ONE     = 64'd1073741824;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

  // Window kinds
  typedef enum logic [2:0] {
    WK_HANN     = 3'd0,
    WK_HAMMING  = 3'd1,
    WK_TRIANGLE = 3'd2,
    WK_WELCH    = 3'd3,
    WK_SINE     = 3'd4
  } window_kind_t;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_KIND   = 3'd0,
    REG_FRAME_LENGTH  = 3'd1,
    REG_POSITION_STEP = 3'd2,
    REG_HAMMING_ALPHA = 3'd3,
    REG_HAMMING_BETA  = 3'd4
  } cfg_reg_t;

  // Reset values
  localparam logic [LEN_W-1:0]   FRAME_LENGTH_RST  = 13'd1024;
  localparam logic [PHASE_W-1:0] POSITION_STEP_RST = 25'd16400;
  localparam logic [15:0]        HAMMING_ALPHA_RST = 16'd17695;
  localparam logic [15:0]        HAMMING_BETA_RST  = 16'd15073;

  typedef logic signed [COS_W-1:0] cos_rom_t [COS_TABLE_DEPTH];

  // One cosine entry: quarter-wave fold, angle scaling, Horner series
  function automatic logic signed [COS_W-1:0] cos_entry(int unsigned k);
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] theta;
    logic [63:0] z;
    logic [63:0] hu;
    logic [63:0] quo;
    logic [1:0]  quad;
    longint      h;
    logic [COS_W-1:0] q;
    t = (64'(k) << 32) / COS_TABLE_DEPTH;
    quad = t[31:30];
    r = {34'd0, t[29:0]};
    a = quad[0] ? (Q30_ONE - r) : r;
    theta = (a * HALF_PI_Q30) >> 30;
    z = (theta * theta) >> 30;
    h = longint'(Q30_ONE);
    for (int i = 0; i < 6; i++) begin
      hu = (h < 0) ? 64'd0 : 64'(h);
      case (i)
        0:       quo = ((z * hu) >> 30) / 64'd132;
        1:       quo = ((z * hu) >> 30) / 64'd90;
        2:       quo = ((z * hu) >> 30) / 64'd56;
        3:       quo = ((z * hu) >> 30) / 64'd30;
        4:       quo = ((z * hu) >> 30) / 64'd12;
        default: quo = ((z * hu) >> 30) / 64'd2;
      endcase
      h = longint'(Q30_ONE) - longint'(quo);
    end
    if (h < 0) h = 0;
    if (h > longint'(Q30_ONE)) h = longint'(Q30_ONE);
    q = COS_W'((64'(h) + 64'd16384) >> 15);
    return (quad == 2'd1 || quad == 2'd2) ? -signed'(q) : signed'(q);
  endfunction

  // Whole table, evaluated at elaboration
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t tbl;
    for (int unsigned k = 0; k < COS_TABLE_DEPTH; k++) begin
      tbl[k] = cos_entry(k);
    end
    return tbl;
  endfunction

endpackage
`default_nettype wire

@@ src/wfa_cos_rom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfa_cos_rom
// Full-turn cosine table with a registered (synchronous) read.
// ----------------------------------------------------------------------------
module wfa_cos_rom (
  input  wire                              clk,
  input  wire                              en,
  input  wire  [wfa_pkg::COS_ADDR_W-1:0]   addr,
  output logic signed [wfa_pkg::COS_W-1:0] q
);
  import wfa_pkg::*;

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // registered read, held while the consuming stage stalls
  always_ff @(posedge clk) begin
    if (en) begin
      q <= COS_ROM[addr];
    end
  end

endmodule
`default_nettype wire

@@ src/window_function_apply.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// window_function_apply
// Streams samples through a Hann, Hamming, triangle, Welch or sine window.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* carries input beats: tdata = sample, tlast = last sample of a frame.
//  - m_* carries result beats: tdata = windowed sample, tlast = copy of the
//    input frame end, tuser = length error (last mark misplaced or overrun).
//  - cfg_* writes one register per beat (index, data); cfg_ready is always
//    high. Write registers only while no beat is in flight.
//  - One beat per cycle sustained while m_tready stays high; each beat passes
//    through three register stages: cosine ROM read, coefficient
//    stage (Hamming and Welch multipliers), then the sample multiply with
//    rounding and saturation in the output register.
//  - Each stage holds its beat when the next one is full, so a bubble-free
//    stream keeps flowing and s_tready drops only when all three stages are
//    full and m_tready is low.
//  - Reset returns registers to their defaults, clears the frame position
//    and phase, and empties the pipeline. The cosine table is a constant
//    ROM, so no fill pass follows reset.
// ----------------------------------------------------------------------------
module window_function_apply (
  input  wire                                 clk,
  input  wire                                 rst,
  // input stream
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [15:0]                         s_tdata,   // [15:0] sample
  input  wire                                 s_tlast,   // frame_end
  // output stream
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [15:0]                         m_tdata,   // [15:0] windowed_sample
  output logic                                m_tlast,   // frame_end_out
  output logic                                m_tuser,   // [0] status
  // register writes
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [wfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [wfa_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wfa_pkg::*;

  // configuration registers
  window_kind_t       window_kind;
  logic [LEN_W-1:0]   frame_length;
  logic [PHASE_W-1:0] position_step;
  logic [15:0]        hamming_alpha;
  logic [15:0]        hamming_beta;

  // frame state
  logic [LEN_W-1:0]   sample_position;
  logic [PHASE_W-1:0] phase_accumulator;
  logic [LEN_W-1:0]   sample_position_next;
  logic [PHASE_W-1:0] phase_accumulator_next;

  // pipeline
  logic                          v1, v2;
  logic                          ready2, ready3;
  logic signed [15:0]            smp1, smp2;
  logic                          last1, last2;
  logic                          err1, err2;
  logic [PHASE_W-1:0]            d1;
  logic signed [COEF_W-1:0]      coef2;
  logic signed [COS_W-1:0]       cos_q;

  logic                          accept;
  logic [LEN_W-1:0]              len_eff;
  logic [LEN_W-1:0]              last_pos;
  logic                          err0;
  logic [PHASE_W-1:0]            x0;
  logic [PHASE_W:0]              two_x;
  logic [PHASE_W:0]              d0_wide;
  logic [PHASE_W-1:0]            turn0;
  logic [COS_ADDR_W-1:0]         cos_addr;
  logic [PHASE_W:0]              acc_sum;

  logic signed [COEF_W-1:0]      coef_hann;
  logic signed [COEF_W-1:0]      coef_ham;
  logic signed [COEF_W-1:0]      coef_tri;
  logic signed [COEF_W-1:0]      coef_welch;
  logic signed [COEF_W-1:0]      coef1;
  logic signed [33:0]            ham_prod;
  logic signed [33:0]            ham_rnd;
  logic signed [19:0]            ham_diff;
  logic [49:0]                   dd;
  logic [PHASE_W:0]              tri_num;
  logic [PHASE_W:0]              welch_num;

  logic signed [33:0]            y_prod;
  logic signed [33:0]            y_rnd;
  logic signed [18:0]            y_q;
  logic signed [15:0]            y_sat;

  // stage handshakes
  assign ready3    = !m_tvalid || m_tready;
  assign ready2    = !v2 || ready3;
  assign s_tready  = !v1 || ready2;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_kind   <= WK_HANN;
      frame_length  <= FRAME_LENGTH_RST;
      position_step <= POSITION_STEP_RST;
      hamming_alpha <= HAMMING_ALPHA_RST;
      hamming_beta  <= HAMMING_BETA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_KIND:   window_kind   <= window_kind_t'(cfg_data[2:0]);
        REG_FRAME_LENGTH:  frame_length  <= cfg_data[LEN_W-1:0];
        REG_POSITION_STEP: position_step <= cfg_data[PHASE_W-1:0];
        REG_HAMMING_ALPHA: hamming_alpha <= cfg_data[15:0];
        REG_HAMMING_BETA:  hamming_beta  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // length check and table address for the incoming beat
  always_comb begin
    if (frame_length < LEN_W'(2)) begin
      len_eff = LEN_W'(2);
    end else if (frame_length > LEN_W'(MAX_LENGTH)) begin
      len_eff = LEN_W'(MAX_LENGTH);
    end else begin
      len_eff = frame_length;
    end
    last_pos = len_eff - LEN_W'(1);
    err0 = (sample_position > last_pos) || (s_tlast && sample_position != last_pos);

    x0 = (phase_accumulator > Q24_ONE) ? Q24_ONE : phase_accumulator;
    two_x = {x0, 1'b0};
    if (two_x >= {1'b0, Q24_ONE}) begin
      d0_wide = two_x - {1'b0, Q24_ONE};
    end else begin
      d0_wide = {1'b0, Q24_ONE} - two_x;
    end
    turn0 = (window_kind == WK_SINE) ? ((x0 >> 1) + SINE_OFFSET) : x0;
    cos_addr = turn0[23 -: COS_ADDR_W];
  end

  // position and phase update
  always_comb begin
    acc_sum = {1'b0, phase_accumulator} + {1'b0, position_step};
    if (s_tlast) begin
      sample_position_next   = '0;
      phase_accumulator_next = '0;
    end else begin
      sample_position_next = (sample_position < LEN_W'(MAX_LENGTH)) ?
                             sample_position + LEN_W'(1) : sample_position;
      phase_accumulator_next = acc_sum[PHASE_W] ? ACC_MAX : acc_sum[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position   <= '0;
      phase_accumulator <= '0;
    end else if (accept) begin
      sample_position   <= sample_position_next;
      phase_accumulator <= phase_accumulator_next;
    end
  end

  // cosine table
  wfa_cos_rom u_cos_rom (
    .clk  (clk),
    .en   (s_tready),
    .addr (cos_addr),
    .q    (cos_q)
  );

  // stage 1: sample, flags and distance from mid-frame
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      smp1  <= signed'(s_tdata);
      last1 <= s_tlast;
      err1  <= err0;
      d1    <= d0_wide[PHASE_W-1:0];
    end
  end

  // coefficient for each window kind
  always_comb begin
    coef_hann = (COEF_W'(32769) - COEF_W'(cos_q)) >>> 1;

    ham_prod = signed'({18'd0, hamming_beta}) * 34'(cos_q);
    ham_rnd  = (ham_prod + 34'sd16384) >>> 15;
    ham_diff = signed'({4'd0, hamming_alpha}) - ham_rnd[19:0];
    coef_ham = ham_diff[COEF_W-1:0];

    tri_num  = {1'b0, Q24_ONE} + (PHASE_W+1)'(256) - {1'b0, d1};
    coef_tri = signed'({1'b0, tri_num[PHASE_W:9]});

    dd = {25'd0, d1} * {25'd0, d1};
    welch_num  = {1'b0, Q24_ONE} + (PHASE_W+1)'(256) - dd[49:24];
    coef_welch = signed'({1'b0, welch_num[PHASE_W:9]});

    case (window_kind)
      WK_HANN:     coef1 = coef_hann;
      WK_HAMMING:  coef1 = coef_ham;
      WK_TRIANGLE: coef1 = coef_tri;
      WK_WELCH:    coef1 = coef_welch;
      WK_SINE:     coef1 = COEF_W'(cos_q);
      default:     coef1 = COEF_W'(32768);
    endcase
  end

  // stage 2: coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      coef2 <= coef1;
      smp2  <= smp1;
      last2 <= last1;
      err2  <= err1;
    end
  end

  // sample times coefficient, round half up, saturate
  always_comb begin
    y_prod = 34'(smp2) * 34'(coef2);
    y_rnd  = y_prod + 34'sd16384;
    y_q    = y_rnd[33:15];
    if (y_q > 19'sd32767) begin
      y_sat = 16'sd32767;
    end else if (y_q < -19'sd32768) begin
      y_sat = -16'sd32768;
    end else begin
      y_sat = y_q[15:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready3) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      m_tdata <= y_sat;
      m_tlast <= last2;
      m_tuser <= err2;
    end
  end

endmodule
`default_nettype wire

@@ src/wfa_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfa_checker
// Port-level checks for the window function block, bound to the top level.
// ----------------------------------------------------------------------------
module wfa_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [15:0] m_tdata,
  input wire        m_tlast,
  input wire        m_tuser
);

  // beats accepted but not yet delivered
  logic [2:0] inflight;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'(in_beat) - 3'(out_beat);
    end
  end

  // stalled result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("result payload changed while stalled");

  // no result without an accepted sample behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight != 3'd0)
    else $error("result beat with no sample in flight");

  // three stages hold at most three samples
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd3)
    else $error("more samples in flight than pipeline stages");

  // empty output stage means the pipeline can take a sample
  a_no_deadlock: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output stage empty");

endmodule

bind window_function_apply wfa_checker u_wfa_checker (.*);
`default_nettype wire
